>>> src/uartb_pkg.sv
// Package with the constants and beat types of the UART transmit ring buffer.
package uartb_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  localparam logic       KIND_WRITE = 1'b0;
  localparam logic       KIND_INT   = 1'b1;
  localparam logic [3:0] CAUSE_TX   = 4'h2;
  localparam logic [3:0] CAUSE_LINE = 4'h6;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       first_of_call;
    logic       last_of_call;
    logic       thr_empty;
    logic [3:0] int_cause;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       read_line_status;
    logic       unhandled_cause;
  } out_item_t;

endpackage

>>> src/uartb_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module uartb_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/uart_tx_ring_buffer.sv
// Top level of the UART transmit ring buffer.
//
// Input channel: an item beat is taken at a rising edge with start high and
// busy low. busy stays low, so a new item may be given in every cycle.
// A write item offers one byte of a write call; an interrupt item carries
// the low nibble of the interrupt identification register.
// Result channel: every item gives exactly one result beat on out_item,
// marked by out_valid for a single cycle, after the input and result registers.
// The receiver cannot stall, so nothing is ever held back.
// Throughput is one item per cycle. The delay comes from the input register and
// the registered read port of the ring memory; a byte stored and sent by the
// same item is forwarded around the memory.
// The ring keeps one slot empty, so it holds at most RING_DEPTH-1 bytes.
// Reset clears both pointers, marks the transmitter idle and drops any item
// in flight. The ring memory itself is not cleared; only written slots are
// ever read.
module uart_tx_ring_buffer
  import uartb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Stage 1: registered input beat.
  logic           s1_valid_r;
  in_item_t       in_r;

  // Ring state.
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic             idle_r, idle_nxt;

  // Stage 2: result without the byte, plus forwarding of a fresh write.
  logic       out_valid_r;
  out_item_t  res_r, res_nxt;
  logic       byp_r;
  logic [7:0] byp_data_r;
  logic [7:0] ram_q;

  logic             is_write, is_int;
  logic [PTR_W-1:0] wr_next;
  logic             store, send, idle_poll, bypass;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_item;
    end
  end

  always_comb begin
    is_write  = s1_valid_r && (in_r.kind == KIND_WRITE);
    is_int    = s1_valid_r && (in_r.kind == KIND_INT);
    wr_next   = next_slot(wp_r);
    // The status poll on the first byte comes before the store.
    idle_poll = idle_r || (in_r.first_of_call && in_r.thr_empty);
    store     = is_write && (wr_next != rp_r);
    wp_nxt    = store ? wr_next : wp_r;
    send      = ((is_write && in_r.last_of_call && idle_poll) ||
                 (is_int && (in_r.int_cause == CAUSE_TX))) && (rp_r != wp_nxt);
    rp_nxt    = send ? next_slot(rp_r) : rp_r;
    // The byte sent is the one just stored when the ring was empty before.
    bypass    = store && (wp_r == rp_r);

    idle_nxt = idle_r;
    if (is_write) begin
      idle_nxt = idle_poll && !send;
    end else if (is_int && (in_r.int_cause == CAUSE_TX)) begin
      idle_nxt = !send;
    end

    res_nxt                  = '0;
    res_nxt.accepted         = store;
    res_nxt.tx_valid         = send;
    res_nxt.read_line_status = is_int && (in_r.int_cause == CAUSE_LINE);
    res_nxt.unhandled_cause  = is_int && (in_r.int_cause != CAUSE_LINE) &&
                               (in_r.int_cause != CAUSE_TX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      wp_r        <= '0;
      idle_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      idle_r      <= idle_nxt;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    byp_r      <= bypass;
    byp_data_r <= in_r.data_byte;
  end

  uartb_ram #(
    .DEPTH(RING_DEPTH),
    .WIDTH(8)
  ) u_ring (
    .clk    (clk),
    .wr_en  (store),
    .wr_addr(wp_r),
    .wr_data(in_r.data_byte),
    .rd_addr(rp_r),
    .rd_data(ram_q)
  );

  always_comb begin
    out_item         = res_r;
    out_item.tx_byte = res_r.tx_valid ? (byp_r ? byp_data_r : ram_q) : 8'h00;
  end

  assign out_valid = out_valid_r;

  // Every accepted item beat yields a result beat, through s1_valid_r and then out_valid_r.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> s1_valid_r ##1 out_valid_r)
    else $error("item beat without a matching result beat");

  // Both pointers stay inside the ring, also for depths that are not powers of two.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rp_r <= PTR_W'(RING_DEPTH - 1)) && (wp_r <= PTR_W'(RING_DEPTH - 1)))
    else $error("ring pointer out of range");

  // A stored byte that is not sent at once leaves the ring non-empty.
  a_store_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (store && !send) |=> (rp_r != wp_r))
    else $error("ring empty after a store");

  // Sending a byte always leaves the transmitter busy.
  a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
    send |=> !idle_r)
    else $error("transmitter idle after a send");

  // A result flags either a stored byte or an interrupt cause, never both.
  a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.accepted &&
                      (res_r.read_line_status || res_r.unhandled_cause)))
    else $error("write and interrupt flags in the same result");

endmodule
